// ===== hdl/rme_pkg.sv =====
// Package with the shared constants and types of the RSA modular exponentiation block.
package rme_pkg;
    localparam int MOD_BITS   = 16;
    localparam int EXP_BITS   = 16;
    localparam int PLAIN_BITS = 8;
    localparam int CIPHER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam int MUL_COUNT  = 2 * EXP_BITS;
    localparam int STEP_COUNT = MUL_COUNT * MOD_BITS;
    localparam logic [CFG_BITS-1:0] EXP_RESET = 16'd3;
    localparam logic [CFG_BITS-1:0] MOD_RESET = 16'd10201;

    typedef enum logic
    {
        REG_EXPONENT = 1'b0,
        REG_MODULUS  = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [MOD_BITS-1:0] base;
        logic [MOD_BITS-1:0] x;
        logic [MOD_BITS-1:0] y;
        logic [MOD_BITS-1:0] r;
    } step_t;

    typedef struct packed
    {
        logic [MOD_BITS-1:0]   rem;
        logic [PLAIN_BITS-1:0] bits;
    } red_t;
endpackage

// ===== hdl/rme_if.sv =====
// Stream interfaces for the plaintext input and the ciphertext output.
interface rme_in_if
    import rme_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PLAIN_BITS-1:0] plain_byte;
    modport source (output valid, output plain_byte, input ready);
    modport sink (input valid, input plain_byte, output ready);
endinterface

interface rme_out_if
    import rme_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CIPHER_BITS-1:0] cipher_value;
    modport source (output valid, output cipher_value, input ready);
    modport sink (input valid, input cipher_value, output ready);
endinterface

// ===== hdl/rme_reduce.sv =====
// Pipelined restoring reduction of the plaintext byte modulo the modulus, one bit per stage.
module rme_reduce
    import rme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_v,
    input  logic [PLAIN_BITS-1:0] in_byte,
    input  logic [MOD_BITS-1:0]   mod_eff,
    output logic                  out_v,
    output logic [MOD_BITS-1:0]   out_rem
);
    logic [PLAIN_BITS-1:0] v_reg;
    red_t                  d_reg [PLAIN_BITS];

    for (genvar k = 0; k < PLAIN_BITS; k++)
    begin : g_stage
        logic              pv;
        red_t              pd;
        red_t              nd;
        logic [MOD_BITS:0] t;

        if (k == 0)
        begin : g_first
            assign pv = in_v;
            assign pd = '{rem: '0, bits: in_byte};
        end
        else
        begin : g_next
            assign pv = v_reg[k-1];
            assign pd = d_reg[k-1];
        end

        always_comb
        begin
            t = {pd.rem, pd.bits[PLAIN_BITS-1]};
            if (t >= {1'b0, mod_eff})
            begin
                t = t - {1'b0, mod_eff};
            end
            nd.rem  = t[MOD_BITS-1:0];
            nd.bits = {pd.bits[PLAIN_BITS-2:0], 1'b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= nd;
            end
        end
    end

    assign out_v   = v_reg[PLAIN_BITS-1];
    assign out_rem = d_reg[PLAIN_BITS-1].rem;
endmodule

// ===== hdl/rme_mulchain.sv =====
// Square-and-multiply chain built from interleaved modular multiply steps, one bit per stage.
module rme_mulchain
    import rme_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_v,
    input  logic [MOD_BITS-1:0] in_base,
    input  logic [EXP_BITS-1:0] exp_eff,
    input  logic [MOD_BITS-1:0] mod_eff,
    output logic                out_v,
    output logic [MOD_BITS-1:0] out_r
);
    localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

    logic [STEP_COUNT-1:0] v_reg;
    step_t                 d_reg [STEP_COUNT];
    logic [MOD_BITS+1:0]   m1;
    logic [MOD_BITS+1:0]   m2;

    assign m1 = {2'b00, mod_eff};
    assign m2 = {1'b0, mod_eff, 1'b0};

    for (genvar k = 0; k < STEP_COUNT; k++)
    begin : g_stage
        localparam int Q  = k / MOD_BITS;
        localparam int J  = MOD_BITS - 1 - (k % MOD_BITS);
        localparam bit FIRST = (k % MOD_BITS) == 0;
        localparam bit SQ = (Q % 2) == 0;
        localparam int EB = EXP_BITS - 1 - Q / 2;

        logic                pv;
        step_t               pd;
        step_t               nd;
        logic [MOD_BITS-1:0] xs;
        logic [MOD_BITS-1:0] ys;
        logic [MOD_BITS-1:0] rin;
        logic [MOD_BITS+1:0] s;

        if (k == 0)
        begin : g_first
            assign pv = in_v;
            assign pd = '{base: in_base, x: '0, y: '0, r: ONE};
        end
        else
        begin : g_next
            assign pv = v_reg[k-1];
            assign pd = d_reg[k-1];
        end

        always_comb
        begin
            if (FIRST)
            begin
                ys  = pd.r;
                rin = '0;
                if (SQ)
                begin
                    xs = pd.r;
                end
                else
                begin
                    xs = exp_eff[EB] ? pd.base : ONE;
                end
            end
            else
            begin
                xs  = pd.x;
                ys  = pd.y;
                rin = pd.r;
            end
            s = {1'b0, rin, 1'b0} + (xs[J] ? {2'b00, ys} : '0);
            if (s >= m2)
            begin
                s = s - m2;
            end
            else if (s >= m1)
            begin
                s = s - m1;
            end
            nd.base = pd.base;
            nd.x    = xs;
            nd.y    = ys;
            nd.r    = s[MOD_BITS-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= nd;
            end
        end
    end

    assign out_v = v_reg[STEP_COUNT-1];
    assign out_r = d_reg[STEP_COUNT-1].r;
endmodule

// ===== hdl/rsa_modexp_encrypt.sv =====
// Throughput: one beat per cycle while the output is not stalled.
// Each stage holds one bit step of a reduction or multiply.
// A stalled output holds the whole pipeline, so no beat is lost or repeated.
// Reset is asynchronous and active low; it clears all valid bits and loads
// exponent 3 and modulus 10201.
module rsa_modexp_encrypt
    import rme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    rme_in_if.sink               in_ch,
    rme_out_if.source            out_ch
);
    logic [CFG_BITS-1:0]    exp_reg;
    logic [CFG_BITS-1:0]    mod_reg;
    logic [EXP_BITS-1:0]    exp_eff;
    logic [MOD_BITS-1:0]    mod_eff;
    logic                   en;
    logic                   red_v;
    logic [MOD_BITS-1:0]    red_rem;
    logic                   mul_v;
    logic [MOD_BITS-1:0]    mul_r;
    logic                   out_v_reg;
    logic [CIPHER_BITS-1:0] out_d_reg;
    logic [CIPHER_BITS-1:0] out_d_next;
    reg_index_t             idx;

    assign pready  = 1'b1;
    assign idx     = reg_index_t'(paddr[2]);
    assign exp_eff = EXP_BITS'(exp_reg);
    assign mod_eff = MOD_BITS'(mod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= EXP_RESET;
            mod_reg <= MOD_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_EXPONENT: exp_reg <= CFG_BITS'(EXP_BITS'(pwdata[CFG_BITS-1:0]));
                REG_MODULUS:  mod_reg <= CFG_BITS'(MOD_BITS'(pwdata[CFG_BITS-1:0]));
                default:      exp_reg <= exp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EXPONENT: prdata = DATA_BITS'(exp_reg);
            REG_MODULUS:  prdata = DATA_BITS'(mod_reg);
            default:      prdata = '0;
        endcase
    end

    assign en           = !out_v_reg || out_ch.ready;
    assign in_ch.ready  = en;

    rme_reduce u_reduce
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (in_ch.valid),
        .in_byte (in_ch.plain_byte),
        .mod_eff (mod_eff),
        .out_v   (red_v),
        .out_rem (red_rem)
    );

    rme_mulchain u_mulchain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (red_v),
        .in_base (red_rem),
        .exp_eff (exp_eff),
        .mod_eff (mod_eff),
        .out_v   (mul_v),
        .out_r   (mul_r)
    );

    assign out_d_next = (mod_eff < MOD_BITS'(2)) ? '0 : CIPHER_BITS'(mul_r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= mul_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg <= out_d_next;
        end
    end

    assign out_ch.valid        = out_v_reg;
    assign out_ch.cipher_value = out_d_reg;

`ifndef ASSERT_OFF
    a_small_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && mod_eff < MOD_BITS'(2)) |-> out_d_reg == '0)
        else $error("Result is not zero for a modulus below two.");

    a_result_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && mod_eff >= MOD_BITS'(2)) |-> MOD_BITS'(out_d_reg) < mod_eff)
        else $error("Result is not reduced below the modulus.");

    a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_v_reg || out_ch.ready))
        else $error("Input ready does not follow the output stall.");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |=> out_v_reg && $stable(mul_v))
        else $error("Pipeline moved while the output was stalled.");
`endif
endmodule
